// ===== rtl/core/mlbf_pkg.sv =====
`default_nettype none

package mlbf_pkg;

	localparam int NUM_LEDS_DEF  = 8;
	localparam int MAX_BURST_DEF = 16;

	localparam int PERIOD_W = 6;
	localparam int DELAY_W  = 8;
	localparam int BURST_W  = 4;

	localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 6'd5;
	localparam logic [PERIOD_W-1:0] FLASH_PERIOD_RST = 6'd1;

	localparam logic [2:0] FUNC_TICK   = 3'd0;
	localparam logic [2:0] FUNC_SET    = 3'd1;
	localparam logic [2:0] FUNC_TOGGLE = 3'd2;
	localparam logic [2:0] FUNC_BLINK  = 3'd3;
	localparam logic [2:0] FUNC_FLASH  = 3'd4;
	localparam logic [2:0] FUNC_QUERY  = 3'd5;

	localparam logic REG_BLINK_PERIOD = 1'b0;
	localparam logic REG_FLASH_PERIOD = 1'b1;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_BLINK = 2'd1,
		MODE_FLASH = 2'd2
	} mode_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] led_index;
		logic       value;
		logic [7:0] burst_count;
	} cmd_t;

	typedef struct packed {
		logic       accepted;
		logic       led_level;
		logic [1:0] led_mode;
		logic [7:0] pin_levels;
	} res_t;

	typedef struct packed {
		mode_t               mode;
		logic [DELAY_W-1:0]  delay_left;
		logic [PERIOD_W-1:0] period;
		logic [BURST_W-1:0]  burst_length;
		logic [BURST_W-1:0]  burst_left;
	} led_ent_t;

endpackage

`default_nettype wire

// ===== rtl/core/mlbf_ram.sv =====
`default_nettype none

module mlbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mlbf_adv.sv =====
`default_nettype none

module mlbf_adv (
	input  wire mlbf_pkg::led_ent_t ent,
	input  wire logic               ent_valid,
	input  wire logic               lvl,
	output mlbf_pkg::led_ent_t      ent_n,
	output logic                    lvl_n,
	output logic                    we
);

	import mlbf_pkg::*;

	logic                running;
	logic [BURST_W-1:0]  bl_dec;
	logic [8:0]          pause_x5;
	logic [DELAY_W-1:0]  pause;

	assign running  = ent_valid && (ent.mode == MODE_BLINK || ent.mode == MODE_FLASH);
	assign bl_dec   = ent.burst_left - 1'b1;
	assign pause_x5 = {1'b0, ent.period, 2'b00} + {3'b000, ent.period};
	assign pause    = pause_x5[8] ? 8'hFF : pause_x5[7:0];
	assign we       = running;

	always_comb begin
		ent_n = ent;
		lvl_n = lvl;
		if (running) begin
			if (ent.delay_left != '0) begin
				ent_n.delay_left = ent.delay_left - 1'b1;
			end else begin
				lvl_n = ~lvl;
				if (ent.burst_length != '0 && lvl) begin
					// falling edge uses up one count of the burst
					ent_n.burst_left = bl_dec;
					if (bl_dec != '0) begin
						ent_n.delay_left = {2'b00, ent.period};
					end else if (ent.mode == MODE_BLINK) begin
						ent_n.delay_left = pause;
						ent_n.burst_left = ent.burst_length;
					end else begin
						ent_n.mode = MODE_OFF;
					end
				end else begin
					ent_n.delay_left = {2'b00, ent.period};
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/multi_led_blink_flash_controller.sv =====
// channel   handshake          payload
// command   start, busy        cmd (func, led_index, value, burst_count)
// result    done               result (accepted, led_level, led_mode, pin_levels)
// config    cfg_we             cfg_addr, cfg_wdata
//
// tick: the advance unit walks the led table one entry a cycle, then reads the addressed led
// other commands: update, table read of the addressed led, result
// done is high for one cycle, in the same cycle that busy drops; the receiver cannot stall
// a new request may start while done is high
// reset: all leds low and off, blink period 5, flash period 1

`default_nettype none

module multi_led_blink_flash_controller #(
	parameter int NUM_LEDS  = mlbf_pkg::NUM_LEDS_DEF,
	parameter int MAX_BURST = mlbf_pkg::MAX_BURST_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire mlbf_pkg::cmd_t                cmd,
	output logic                               done,
	output mlbf_pkg::res_t                     result,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_addr,
	input  wire logic [mlbf_pkg::PERIOD_W-1:0] cfg_wdata
);

	import mlbf_pkg::*;

	localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int PIN_N = (NUM_LEDS < 8) ? NUM_LEDS : 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);
	localparam logic [7:0] NUM_LEDS_B = 8'(NUM_LEDS);
	localparam logic [7:0] MAX_BURST_B = 8'(MAX_BURST);
	localparam int ENT_W = $bits(led_ent_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_FIN_RD,
		S_FIN
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic                   acc_q;
	logic [IDX_W-1:0]       p_q;
	logic [NUM_LEDS-1:0]    level_q;
	logic [NUM_LEDS-1:0]    valid_q;
	logic [PERIOD_W-1:0]    blink_q;
	logic [PERIOD_W-1:0]    flash_q;
	logic                   done_q;
	res_t                   result_q;

	logic                   in_ok;
	logic                   burst_ok;
	logic [IDX_W-1:0]       in_idx;
	logic                   q_ok;
	logic [IDX_W-1:0]       q_idx;
	led_ent_t               new_ent;
	led_ent_t               rd_ent;
	led_ent_t               adv_ent;
	logic                   adv_lvl;
	logic                   adv_we;
	logic [7:0]             pins;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENT_W-1:0]       ram_wdata;
	logic                   ram_re;
	logic [IDX_W-1:0]       ram_raddr;
	logic [ENT_W-1:0]       ram_rdata;

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign result   = result_q;

	assign in_ok    = (cmd.led_index < NUM_LEDS_B);
	assign burst_ok = (cmd.burst_count < MAX_BURST_B);
	assign in_idx   = cmd.led_index[IDX_W-1:0];
	assign q_ok     = (cmd_q.led_index < NUM_LEDS_B);
	assign q_idx    = cmd_q.led_index[IDX_W-1:0];
	assign rd_ent   = led_ent_t'(ram_rdata);

	always_comb begin
		new_ent              = '0;
		new_ent.mode         = (cmd.func == FUNC_BLINK) ? MODE_BLINK : MODE_FLASH;
		new_ent.period       = (cmd.func == FUNC_BLINK) ? blink_q : flash_q;
		new_ent.delay_left   = {2'b00, new_ent.period};
		new_ent.burst_length = cmd.burst_count[BURST_W-1:0];
		new_ent.burst_left   = cmd.burst_count[BURST_W-1:0];
	end

	always_comb begin
		pins = '0;
		for (int i = 0; i < PIN_N; i++) begin
			pins[i] = level_q[i];
		end
	end

	mlbf_adv u_adv (
		.ent       (rd_ent),
		.ent_valid (valid_q[p_q]),
		.lvl       (level_q[p_q]),
		.ent_n     (adv_ent),
		.lvl_n     (adv_lvl),
		.we        (adv_we)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = ENT_W'(adv_ent);
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd.func == FUNC_TICK) begin
						ram_re = 1'b1;
					end else if ((cmd.func == FUNC_BLINK || cmd.func == FUNC_FLASH)
							&& in_ok && burst_ok) begin
						ram_we    = 1'b1;
						ram_waddr = in_idx;
						ram_wdata = ENT_W'(new_ent);
					end
				end
			end
			S_SWEEP: begin
				ram_we = adv_we;
				if (p_q != LAST_IDX) begin
					ram_re    = 1'b1;
					ram_raddr = p_q + 1'b1;
				end
			end
			S_FIN_RD: begin
				ram_re    = 1'b1;
				ram_raddr = q_idx;
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	mlbf_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_LEDS)
	) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			acc_q    <= 1'b0;
			p_q      <= '0;
			level_q  <= '0;
			valid_q  <= '0;
			blink_q  <= BLINK_PERIOD_RST;
			flash_q  <= FLASH_PERIOD_RST;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_BLINK_PERIOD: blink_q <= cfg_wdata;
					REG_FLASH_PERIOD: flash_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						acc_q   <= 1'b0;
						state_q <= S_FIN_RD;
						unique case (cmd.func) inside
							FUNC_TICK: begin
								acc_q   <= 1'b1;
								p_q     <= '0;
								state_q <= S_SWEEP;
							end
							FUNC_SET: begin
								if (in_ok) begin
									level_q[in_idx] <= cmd.value;
									// an invalid entry reads as mode off
									valid_q[in_idx] <= 1'b0;
									acc_q           <= 1'b1;
								end
							end
							FUNC_TOGGLE: begin
								if (in_ok) begin
									level_q[in_idx] <= ~level_q[in_idx];
									acc_q           <= 1'b1;
								end
							end
							FUNC_BLINK, FUNC_FLASH: begin
								if (in_ok && burst_ok) begin
									level_q[in_idx] <= 1'b1;
									valid_q[in_idx] <= 1'b1;
									acc_q           <= 1'b1;
								end
							end
							FUNC_QUERY: begin
								acc_q <= in_ok;
							end
							default: begin
							end
						endcase
					end
				end
				S_SWEEP: begin
					level_q[p_q] <= adv_lvl;
					p_q          <= p_q + 1'b1;
					if (p_q == LAST_IDX) begin
						state_q <= S_FIN_RD;
					end
				end
				S_FIN_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					done_q              <= 1'b1;
					result_q.accepted   <= acc_q;
					result_q.led_level  <= q_ok && level_q[q_idx];
					result_q.led_mode   <= (q_ok && valid_q[q_idx]) ? rd_ent.mode : MODE_OFF;
					result_q.pin_levels <= pins;
					state_q             <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIN))
		else $error("result strobe without finish state");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.led_mode != 2'd3))
		else $error("unknown mode reported");
`endif

endmodule

`default_nettype wire

// ===== test/multi_led_blink_flash_controller_tb.sv =====
module multi_led_blink_flash_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mlbf_pkg::*;

	localparam int LEDS = NUM_LEDS_DEF;
	localparam int SETTLE_CYCLES = NUM_LEDS_DEF + 12;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int CMD_W = $bits(cmd_t);

	class led_scoreboard;
		res_t expected_q[$];
		int unsigned mismatches;
		logic [PERIOD_W-1:0] blink_period;
		logic [PERIOD_W-1:0] flash_period;
		logic level[LEDS];
		mode_t mode[LEDS];
		logic [7:0] delay_left[LEDS];
		logic [7:0] period[LEDS];
		logic [3:0] burst_length[LEDS];
		logic [3:0] burst_left[LEDS];

		function new();
			mismatches = 0;
			blink_period = BLINK_PERIOD_RST;
			flash_period = FLASH_PERIOD_RST;
			for (int i = 0; i < LEDS; i++) begin
				level[i] = 1'b0;
				mode[i] = MODE_OFF;
				delay_left[i] = '0;
				period[i] = '0;
				burst_length[i] = '0;
				burst_left[i] = '0;
			end
		endfunction

		function void set_register(logic addr, logic [PERIOD_W-1:0] data);
			if (addr == REG_BLINK_PERIOD) begin
				blink_period = data;
			end else begin
				flash_period = data;
			end
		endfunction

		function void advance_led(int i);
			int unsigned pause;
			if (mode[i] != MODE_BLINK && mode[i] != MODE_FLASH)
				return;
			if (delay_left[i] != 0) begin
				delay_left[i] = delay_left[i] - 8'd1;
				return;
			end
			level[i] = ~level[i];
			if (burst_length[i] != 0 && level[i] == 1'b0) begin
				burst_left[i] = burst_left[i] - 4'd1;
				if (burst_left[i] != 0) begin
					delay_left[i] = period[i];
				end else if (mode[i] == MODE_BLINK) begin
					// pause after a blink burst, clamped to the delay width
					pause = period[i] * 5;
					delay_left[i] = (pause > 255) ? 8'd255 : pause[7:0];
					burst_left[i] = burst_length[i];
				end else begin
					mode[i] = MODE_OFF;
				end
			end else begin
				delay_left[i] = period[i];
			end
		endfunction

		function void start_run(int i, mode_t m, logic [PERIOD_W-1:0] per, logic [7:0] count);
			period[i] = {2'b00, per};
			mode[i] = m;
			burst_length[i] = count[3:0];
			burst_left[i] = count[3:0];
			delay_left[i] = {2'b00, per};
			level[i] = 1'b1;
		endfunction

		function void note_request(cmd_t c);
			res_t r;
			logic valid;
			int idx;
			valid = c.led_index < LEDS;
			idx = c.led_index;
			r = '0;
			case (c.func)
				FUNC_TICK: begin
					for (int i = 0; i < LEDS; i++)
						advance_led(i);
					r.accepted = 1'b1;
				end
				FUNC_SET: begin
					if (valid) begin
						level[idx] = c.value;
						mode[idx] = MODE_OFF;
						r.accepted = 1'b1;
					end
				end
				FUNC_TOGGLE: begin
					if (valid) begin
						level[idx] = ~level[idx];
						r.accepted = 1'b1;
					end
				end
				FUNC_BLINK, FUNC_FLASH: begin
					if (valid && c.burst_count < MAX_BURST_DEF) begin
						if (c.func == FUNC_BLINK)
							start_run(idx, MODE_BLINK, blink_period, c.burst_count);
						else
							start_run(idx, MODE_FLASH, flash_period, c.burst_count);
						r.accepted = 1'b1;
					end
				end
				FUNC_QUERY: begin
					r.accepted = valid;
				end
				default: begin
				end
			endcase
			for (int i = 0; i < LEDS && i < 8; i++)
				r.pin_levels[i] = level[i];
			if (valid) begin
				r.led_level = level[idx];
				r.led_mode = mode[idx];
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no request pending:",
						" acc %0b lvl %0b mode %0d pins %02h",
						got.accepted, got.led_level, got.led_mode, got.pin_levels);
				return;
			end
			want = expected_q.pop_front();
			if (got.accepted !== want.accepted || got.led_level !== want.led_level ||
					got.led_mode !== want.led_mode || got.pin_levels !== want.pin_levels) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected acc %0b lvl %0b mode %0d pins %02h,",
						want.accepted, want.led_level, want.led_mode, want.pin_levels,
						" got acc %0b lvl %0b mode %0d pins %02h",
						got.accepted, got.led_level, got.led_mode, got.pin_levels);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t result;
	logic cfg_we;
	logic cfg_addr;
	logic [PERIOD_W-1:0] cfg_wdata;

	led_scoreboard board;
	int unsigned cycle_count;
	bit steady;

	multi_led_blink_flash_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	function automatic cmd_t build_cmd(logic [2:0] f, logic [7:0] idx, logic v, logic [7:0] cnt);
		cmd_t c;
		c.func = f;
		c.led_index = idx;
		c.value = v;
		c.burst_count = cnt;
		return c;
	endfunction

	function automatic cmd_t random_cmd(int unsigned tick_pct);
		cmd_t c;
		int unsigned pick;
		c = CMD_W'($urandom);
		c.led_index = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(LEDS, 255))
			: 8'($urandom_range(0, LEDS - 1));
		c.burst_count = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(MAX_BURST_DEF, 255))
			: ($urandom_range(0, 1) ? 8'($urandom_range(0, 4))
			: 8'($urandom_range(0, MAX_BURST_DEF - 1)));
		if ($urandom_range(0, 99) < tick_pct) begin
			c.func = FUNC_TICK;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 12)
				c.func = FUNC_SET;
			else if (pick < 22)
				c.func = FUNC_TOGGLE;
			else if (pick < 50)
				c.func = FUNC_BLINK;
			else if (pick < 78)
				c.func = FUNC_FLASH;
			else if (pick < 95)
				c.func = FUNC_QUERY;
			else
				c.func = 3'($urandom_range(6, 7));
		end
		return c;
	endfunction

	task automatic send_request(input cmd_t c);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			steady = ~steady;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= CMD_W'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		board.note_request(c);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic addr, input logic [PERIOD_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		board.set_register(addr, data);
	endtask

	task automatic configure(input logic [PERIOD_W-1:0] bp, input logic [PERIOD_W-1:0] fp);
		if ($urandom_range(0, 1)) begin
			write_register(REG_BLINK_PERIOD, bp);
			write_register(REG_FLASH_PERIOD, fp);
		end else begin
			write_register(REG_FLASH_PERIOD, fp);
			write_register(REG_BLINK_PERIOD, bp);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [PERIOD_W-1:0] bp, input logic [PERIOD_W-1:0] fp,
			input int unsigned count, input int unsigned tick_pct);
		configure(bp, fp);
		repeat (count)
			send_request(random_cmd(tick_pct));
		drain();
	endtask

	initial begin
		board = new();
		cycle_count = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_addr = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values of both periods
		send_request(build_cmd(FUNC_SET, 8'd0, 1'b1, 8'd0));
		send_request(build_cmd(FUNC_SET, 8'd7, 1'b0, 8'd0));
		send_request(build_cmd(FUNC_SET, 8'd8, 1'b1, 8'd0));
		send_request(build_cmd(FUNC_SET, 8'd255, 1'b1, 8'd255));
		send_request(build_cmd(FUNC_TOGGLE, 8'd3, 1'b0, 8'd0));
		send_request(build_cmd(FUNC_TOGGLE, 8'd200, 1'b0, 8'd0));
		send_request(build_cmd(FUNC_QUERY, 8'd3, 1'b0, 8'd0));
		send_request(build_cmd(FUNC_BLINK, 8'd1, 1'b0, 8'd0));
		send_request(build_cmd(FUNC_BLINK, 8'd2, 1'b0, 8'd15));
		send_request(build_cmd(FUNC_BLINK, 8'd2, 1'b0, 8'd16));
		send_request(build_cmd(FUNC_BLINK, 8'd255, 1'b1, 8'd255));
		send_request(build_cmd(FUNC_FLASH, 8'd4, 1'b0, 8'd1));
		send_request(build_cmd(FUNC_FLASH, 8'd5, 1'b0, 8'd255));
		send_request(build_cmd(FUNC_FLASH, 8'd6, 1'b1, 8'd0));
		send_request(build_cmd(FUNC_QUERY, 8'd4, 1'b0, 8'd0));
		send_request(build_cmd(FUNC_QUERY, 8'd8, 1'b0, 8'd0));
		send_request(build_cmd(3'd6, 8'd0, 1'b0, 8'd0));
		send_request(build_cmd(3'd7, 8'd255, 1'b1, 8'd255));
		send_request(build_cmd(FUNC_TOGGLE, 8'd1, 1'b0, 8'd0));
		repeat (6)
			send_request(build_cmd(FUNC_TICK, 8'd4, 1'b0, 8'd0));
		send_request(build_cmd(FUNC_SET, 8'd2, 1'b0, 8'd0));
		drain();

		run_phase(6'd5, 6'd1, 250, 55);
		run_phase(6'd0, 6'd0, 250, 55);
		run_phase(6'd63, 6'd63, 200, 70);
		// long blink periods push the burst pause into saturation
		run_phase(6'd52, 6'd2, 300, 85);
		run_phase(6'd2, 6'd1, 250, 55);
		run_phase(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 300, 60);

		if (board.mismatches == 0 && board.expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mlbf_pkg.sv
rtl/core/mlbf_ram.sv
rtl/core/mlbf_adv.sv
rtl/core/multi_led_blink_flash_controller.sv
test/multi_led_blink_flash_controller_tb.sv
